// ===== src/plid_pkg.sv =====
// Package: shared types and constants for the positional list unit.
`default_nettype none
package plid_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [WORD_W-1:0]  load;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/plid_cell.sv =====
// Module: one storage cell of the shifting list chain.
`default_nettype none
module plid_cell (
    input  wire logic                       clk,
    input  wire plid_pkg::cell_ctrl_t       ctrl,
    input  wire logic [plid_pkg::WORD_W-1:0] prev,
    input  wire logic [plid_pkg::WORD_W-1:0] next,
    output logic      [plid_pkg::WORD_W-1:0] q
);
    import plid_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        case (ctrl.cmd)
            CELL_HOLD:      data_next = data_reg;
            CELL_LOAD:      data_next = ctrl.load;
            CELL_FROM_PREV: data_next = prev;
            CELL_FROM_NEXT: data_next = next;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
`default_nettype wire

// ===== src/positional_list_insert_delete_unit.sv =====
// Module: top level of the positional list insert/delete unit.
// Insert and delete shift the chain of cells in place, and the single result word appears on
// the outputs, marked by done, in the cycle after start was taken; a new command can be taken
// in every cycle while busy is low. A dump of a list of N elements keeps busy high while the
// chain rotates one cell toward the head per cycle, emitting one word per cycle from head to
// tail (at most sixteen, the last marked by last), registered from the head cell; when the
// dump ends the list is back in its original order. An empty dump gives one word with the
// empty status. Results cannot be held off: each word is valid for one cycle.
`default_nettype none
module positional_list_insert_delete_unit #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  opcode,
    input  wire logic [plid_pkg::POS_W-1:0]  position,
    input  wire logic [plid_pkg::WORD_W-1:0] value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [plid_pkg::WORD_W-1:0]      element,
    output logic [plid_pkg::LEN_W-1:0]       length,
    output logic                             last
);
    import plid_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam int NMAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    state_t            state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] element_reg, element_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              ins_ok, del_ok;
    logic              do_ins, do_del, do_rot;
    logic [CW-1:0]     len_x, pos_x, cnt_x, dump_n;
    logic [CW-1:0]     len_res;
    logic [WORD_W-1:0] load_bus;
    logic [WORD_W-1:0] q [DEPTH];

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_DUMP);
    assign len_x  = CW'(len_reg);
    assign pos_x  = CW'(position);
    assign cnt_x  = CW'(cnt_reg);
    assign dump_n = (len_x > CW'(NMAX)) ? CW'(NMAX) : len_x;

    assign ins_ok = (len_x < CW'(DEPTH)) && (pos_x != '0) && (pos_x <= len_x + CW'(1));
    assign del_ok = (pos_x != '0) && (pos_x <= len_x);
    assign do_ins = accept && (opcode_t'(opcode) == OP_INSERT) && ins_ok;
    assign do_del = accept && (opcode_t'(opcode) == OP_DELETE) && del_ok;
    assign do_rot = busy;
    assign load_bus = do_rot ? q[0] : value;

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        cell_ctrl_t        ctrl;
        logic [WORD_W-1:0] prev_d, next_d;

        always_comb
        begin
            ctrl.load = load_bus;
            ctrl.cmd  = CELL_HOLD;
            if (do_ins)
            begin
                if (IDX == pos_x - CW'(1))
                    ctrl.cmd = CELL_LOAD;
                else if ((IDX > pos_x - CW'(1)) && (IDX <= len_x))
                    ctrl.cmd = CELL_FROM_PREV;
            end
            else if (do_del)
            begin
                if ((IDX >= pos_x - CW'(1)) && (IDX + CW'(1) < len_x))
                    ctrl.cmd = CELL_FROM_NEXT;
            end
            else if (do_rot)
            begin
                if (IDX + CW'(1) < len_x)
                    ctrl.cmd = CELL_FROM_NEXT;
                else if (IDX + CW'(1) == len_x)
                    ctrl.cmd = CELL_LOAD;
            end
        end

        if (i == 0)
        begin : g_head
            assign prev_d = load_bus;
        end
        else
        begin : g_body
            assign prev_d = q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = q[0];
        end
        else
        begin : g_inner
            assign next_d = q[i+1];
        end

        plid_cell u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .prev (prev_d),
            .next (next_d),
            .q    (q[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        status_next  = STAT_OK;
        element_next = '0;
        last_next    = 1'b1;
        len_res      = len_x;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (opcode_t'(opcode))
                        OP_INSERT:
                        begin
                            if (len_x >= CW'(DEPTH))
                                status_next = STAT_FULL;
                            else if (!ins_ok)
                                status_next = STAT_RANGE;
                            else
                                len_res = len_x + CW'(1);
                        end
                        OP_DELETE:
                        begin
                            if (!del_ok)
                                status_next = STAT_RANGE;
                            else
                                len_res = len_x - CW'(1);
                        end
                        OP_DUMP:
                        begin
                            if (len_reg == '0)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_DUMP;
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                    len_next = LW'(len_res);
                end
            end
            S_DUMP:
            begin
                done_next    = (cnt_x < CW'(MAX_RESULTS));
                element_next = q[0];
                last_next    = (cnt_x + CW'(1) == dump_n);
                cnt_next     = cnt_reg + LW'(1);
                if (cnt_x + CW'(1) == len_x)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        length_next = LEN_W'(len_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        length_reg  <= length_next;
        last_reg    <= last_next;
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign element = element_reg;
    assign length  = length_reg;
    assign last    = last_reg;

`ifndef SYNTH
    a_edit_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode_t'(opcode) != OP_DUMP)) |=> (done && last))
        else $error("edit did not produce a result word");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (len_reg != '0))
        else $error("dump running on empty list");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && (cnt_x + CW'(1) == len_x) && (len_x <= CW'(MAX_RESULTS)))
        |=> (!busy && done && last))
        else $error("dump did not end with a last word");
`endif

endmodule
`default_nettype wire

// ===== tb/positional_list_insert_delete_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench: positional list insert/delete unit checked word by word against a list model.
module positional_list_insert_delete_unit_test;
    import plid_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  element;
        logic [LEN_W-1:0]   length;
        logic               last;
    } list_word_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        opcode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
    logic              done;
    logic [1:0]        status;
    logic [WORD_W-1:0] element;
    logic [LEN_W-1:0]  length;
    logic              last;

    logic [WORD_W-1:0] list_cells [LIST_DEPTH];
    int                list_count;
    list_word_t        pending_words [$];
    int                error_count = 0;
    int                idle_cycles = 0;
    bit                gaps_on;

    positional_list_insert_delete_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .position (position),
        .value    (value),
        .done     (done),
        .status   (status),
        .element  (element),
        .length   (length),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // list model: applies one accepted command and queues the words it should produce
    task automatic apply_list_op(opcode_t op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
        list_word_t w;
        int         p;
        int         n;
        int         i;
        p = pos;
        w = '{status: STAT_OK, element: '0, length: '0, last: 1'b1};
        case (op)
            OP_INSERT:
            begin
                if (list_count >= LIST_DEPTH)
                    w.status = STAT_FULL;
                else if (p < 1 || p > list_count + 1)
                    w.status = STAT_RANGE;
                else
                begin
                    for (i = list_count; i > p - 1; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[p - 1] = val;
                    list_count++;
                end
                w.length = list_count[LEN_W-1:0];
                pending_words.push_back(w);
            end
            OP_DELETE:
            begin
                if (p < 1 || p > list_count)
                    w.status = STAT_RANGE;
                else
                begin
                    for (i = p - 1; i + 1 < list_count; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_count--;
                end
                w.length = list_count[LEN_W-1:0];
                pending_words.push_back(w);
            end
            OP_DUMP:
            begin
                w.length = list_count[LEN_W-1:0];
                if (list_count == 0)
                begin
                    w.status = STAT_EMPTY;
                    pending_words.push_back(w);
                end
                else
                begin
                    n = (list_count > MAX_RESULTS) ? MAX_RESULTS : list_count;
                    for (i = 0; i < n; i++)
                    begin
                        w.element = list_cells[i];
                        w.last    = (i == n - 1);
                        pending_words.push_back(w);
                    end
                end
            end
            default:
            begin
                w.length = list_count[LEN_W-1:0];
                pending_words.push_back(w);
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge where the command was taken
    task automatic send_word(opcode_t op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
        if (gaps_on && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_list_op(op, pos, val);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_word(int insert_pct);
        int               roll;
        opcode_t          op;
        logic [POS_W-1:0] pos;
        roll = $urandom_range(99);
        if (roll < insert_pct)
            op = OP_INSERT;
        else if (roll < 85)
            op = OP_DELETE;
        else if (roll < 97)
            op = OP_DUMP;
        else
            op = OP_NOP;
        if ($urandom_range(99) < 10)
            pos = POS_W'($urandom_range(31));
        else if (op == OP_INSERT)
            pos = POS_W'($urandom_range(1, list_count + 1));
        else
            pos = (list_count == 0) ? POS_W'(1) : POS_W'($urandom_range(1, list_count));
        send_word(op, pos, pick_value());
    endtask

    task automatic test_edits_and_dump();
        send_word(OP_DUMP, 1, '0);
        send_word(OP_DELETE, 1, '0);
        send_word(OP_INSERT, 0, 32'h1234_5678);
        send_word(OP_INSERT, 2, 32'h1234_5678);
        send_word(OP_INSERT, 1, 32'h8000_0000);
        send_word(OP_INSERT, 2, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 1, 32'h0000_0000);
        send_word(OP_INSERT, 3, 32'hFFFF_FFFF);
        send_word(OP_NOP, 31, 32'hA5A5_5A5A);
        send_word(OP_DUMP, 0, '0);
        send_word(OP_DELETE, 0, '0);
        send_word(OP_DELETE, 5, '0);
        send_word(OP_DELETE, 4, '0);
        send_word(OP_DELETE, 1, '0);
        send_word(OP_DELETE, 31, '0);
        send_word(OP_DUMP, 16, '1);
    endtask

    task automatic test_full_list();
        while (list_count < LIST_DEPTH)
            send_word(OP_INSERT, POS_W'($urandom_range(1, list_count + 1)), pick_value());
        send_word(OP_INSERT, 0, 32'hDEAD_BEEF);
        send_word(OP_INSERT, 17, 32'hDEAD_BEEF);
        send_word(OP_DUMP, 0, '0);
        send_word(OP_DELETE, 17, '0);
        send_word(OP_DELETE, 16, '0);
        send_word(OP_INSERT, 17, 32'h0BAD_F00D);
        send_word(OP_INSERT, 16, 32'h0BAD_F00D);
        send_word(OP_DUMP, 0, '0);
    endtask

    task automatic test_random_traffic();
        int k;
        gaps_on = 1'b0;
        for (k = 0; k < 40; k++)
            send_random_word(60);
        gaps_on = 1'b1;
        for (k = 0; k < 40; k++)
            send_random_word(60);
        for (k = 0; k < 40; k++)
            send_random_word(25);
    endtask

    always @(posedge clk)
    begin
        list_word_t exp;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: status %0d element %h length %0d last %0d",
                       status, element, length, last);
                error_count++;
            end
            else
            begin
                exp = pending_words.pop_front();
                if (status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, status);
                    error_count++;
                end
                if (element !== exp.element)
                begin
                    $error("element: expected %h, got %h", exp.element, element);
                    error_count++;
                end
                if (length !== exp.length)
                begin
                    $error("length: expected %0d, got %0d", exp.length, length);
                    error_count++;
                end
                if (last !== exp.last)
                begin
                    $error("last: expected %0d, got %0d", exp.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("positional_list_insert_delete_unit_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_INSERT;
        position    = '0;
        value       = '0;
        list_count  = 0;
        gaps_on     = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edits_and_dump();
        test_full_list();
        test_random_traffic();

        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("positional_list_insert_delete_unit_test: done, clean");
        else
            $display("positional_list_insert_delete_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== positional_list_insert_delete_unit.f =====
src/plid_pkg.sv
src/plid_cell.sv
src/positional_list_insert_delete_unit.sv
tb/positional_list_insert_delete_unit_test.sv
